### rtl/core/pal_pkg.sv
// Package for the positional array list unit: capacity, derived widths, the
// operation and status codes and the control bundle that the top level sends
// down the chain of cells. No dependencies.
`default_nettype none

package pal_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMP_W    = ((LEN_W > 6) ? LEN_W : 6) + 1;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [IDX_W-1:0]         pidx;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         len;
    } pal_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/pal_cell.sv
// One cell of the list: holds one entry, shifts from its neighbors on insert
// or delete, and compares its entry with the search value.
// Depends on pal_pkg.
`default_nettype none

module pal_cell (
    input  wire logic                             clk,
    input  wire pal_pkg::pal_ctrl_t               ctrl,
    input  wire logic [pal_pkg::IDX_W-1:0]        idx,
    input  wire logic signed [pal_pkg::DATA_W-1:0] left,
    input  wire logic signed [pal_pkg::DATA_W-1:0] right,
    output logic signed [pal_pkg::DATA_W-1:0]      stored,
    output logic                                  match,
    output logic signed [pal_pkg::DATA_W-1:0]      tap
);

    logic signed [pal_pkg::DATA_W-1:0] data_reg;
    logic signed [pal_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (idx == ctrl.pidx)
            begin
                data_next = ctrl.value;
            end
            else if (idx > ctrl.pidx)
            begin
                data_next = left;
            end
        end
        else if (ctrl.del && (idx >= ctrl.pidx))
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stored = data_reg;
    assign match  = (pal_pkg::LEN_W'(idx) < ctrl.len) && (data_reg == ctrl.value);
    assign tap    = (idx == ctrl.pidx) ? data_reg : '0;

endmodule

`default_nettype wire

### rtl/core/pal_chain.sv
// Row of list cells with neighbor links, the first-match encoder for search
// and the selection of the entry at the delete position.
// Depends on pal_pkg and pal_cell.
`default_nettype none

module pal_chain (
    input  wire logic                              clk,
    input  wire pal_pkg::pal_ctrl_t                ctrl,
    output logic [pal_pkg::LEN_W-1:0]              found,
    output logic signed [pal_pkg::DATA_W-1:0]      removed
);

    logic signed [pal_pkg::DATA_W-1:0] vals [pal_pkg::CAPACITY];
    logic signed [pal_pkg::DATA_W-1:0] taps [pal_pkg::CAPACITY];
    logic [pal_pkg::CAPACITY-1:0]      match_vec;

    for (genvar i = 0; i < pal_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] left_val;
        logic signed [pal_pkg::DATA_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_left
            assign left_val = vals[i-1];
        end

        if (i == pal_pkg::CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_right
            assign right_val = vals[i+1];
        end

        pal_cell u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .idx    (pal_pkg::IDX_W'(i)),
            .left   (left_val),
            .right  (right_val),
            .stored (vals[i]),
            .match  (match_vec[i]),
            .tap    (taps[i])
        );
    end

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < pal_pkg::CAPACITY; i++)
        begin
            removed = removed | taps[i];
        end
    end

    always_comb
    begin
        found = '0;
        for (int i = pal_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                found = pal_pkg::LEN_W'(i + 1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/positional_array_list_unit.sv
// Top level of the positional array list unit: stream handshakes, operation
// register, length register, status decode and result register.
// Depends on pal_pkg and pal_chain.
//
// Usage: each transaction on the s_ side carries one operation (insert,
// delete or search) and produces exactly one result transaction on the m_
// side with a status, the removed entry, the found position and the length.
// An accepted operation is held in an operation register and executes across
// the whole chain of cells at once when the output register is free or being
// taken; its result is then held in the output register and offered from
// there. One operation per cycle is sustained while the receiver takes
// results; the whole chain of cells is updated together.
// When the receiver stalls, the pending result holds in the output register
// and one further operation may be accepted and held; s_tready then drops.
// Reset clears the length to zero and empties both registers; entry contents
// are not cleared, since entries at or beyond the length are never read.
`default_nettype none

module positional_array_list_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // kind[1:0], position[7:2], value[39:8]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], removed_value[33:2], found_position[39:34],
    // length_after[45:40], zero[47:46]
    output logic [47:0]      m_tdata
);

    logic                               op_valid_reg;
    pal_pkg::kind_t                     kind_reg;
    logic [5:0]                         pos_reg;
    logic signed [pal_pkg::DATA_W-1:0]  val_reg;
    logic [pal_pkg::LEN_W-1:0]          len_reg;
    logic [pal_pkg::LEN_W-1:0]          len_next;
    logic                               out_valid_reg;
    pal_pkg::status_t                   status_reg;
    pal_pkg::status_t                   status_next;
    logic signed [pal_pkg::DATA_W-1:0]  removed_reg;
    logic signed [pal_pkg::DATA_W-1:0]  removed_next;
    logic [pal_pkg::LEN_W-1:0]          found_reg;
    logic [pal_pkg::LEN_W-1:0]          found_next;
    logic [pal_pkg::LEN_W-1:0]          length_reg;

    logic                               in_fire;
    logic                               exec_fire;
    logic [pal_pkg::CMP_W-1:0]          pos_ext;
    logic [pal_pkg::CMP_W-1:0]          len_ext;
    logic                               ins_bad;
    logic                               ins_full;
    logic                               del_bad;
    logic                               ins_ok;
    logic                               del_ok;
    pal_pkg::pal_ctrl_t                 ctrl;
    logic [pal_pkg::LEN_W-1:0]          chain_found;
    logic signed [pal_pkg::DATA_W-1:0]  chain_removed;

    assign exec_fire = op_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !op_valid_reg || exec_fire;
    assign in_fire   = s_tvalid && s_tready;

    assign pos_ext  = pal_pkg::CMP_W'(pos_reg);
    assign len_ext  = pal_pkg::CMP_W'(len_reg);
    assign ins_bad  = (pos_ext == '0) || (pos_ext > (len_ext + pal_pkg::CMP_W'(1)));
    assign ins_full = (len_ext >= pal_pkg::CMP_W'(pal_pkg::CAPACITY));
    assign del_bad  = (pos_ext == '0) || (pos_ext > len_ext);
    assign ins_ok   = (kind_reg == pal_pkg::KIND_INSERT) && !ins_bad && !ins_full;
    assign del_ok   = (kind_reg == pal_pkg::KIND_DELETE) && !del_bad;

    assign ctrl.ins   = exec_fire && ins_ok;
    assign ctrl.del   = exec_fire && del_ok;
    assign ctrl.pidx  = pal_pkg::IDX_W'(pos_ext - pal_pkg::CMP_W'(1));
    assign ctrl.value = val_reg;
    assign ctrl.len   = len_reg;

    pal_chain u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .found   (chain_found),
        .removed (chain_removed)
    );

    always_comb
    begin
        status_next  = pal_pkg::ST_OK;
        removed_next = '0;
        found_next   = '0;
        len_next     = len_reg;
        unique case (kind_reg)
            pal_pkg::KIND_INSERT:
            begin
                if (ins_bad)
                begin
                    status_next = pal_pkg::ST_BADPOS;
                end
                else if (ins_full)
                begin
                    status_next = pal_pkg::ST_FULL;
                end
                else
                begin
                    len_next = len_reg + pal_pkg::LEN_W'(1);
                end
            end
            pal_pkg::KIND_DELETE:
            begin
                if (del_bad)
                begin
                    status_next = pal_pkg::ST_BADPOS;
                end
                else
                begin
                    removed_next = chain_removed;
                    len_next     = len_reg - pal_pkg::LEN_W'(1);
                end
            end
            pal_pkg::KIND_SEARCH:
            begin
                found_next  = chain_found;
                status_next = (chain_found == '0) ? pal_pkg::ST_NOTFOUND : pal_pkg::ST_OK;
            end
            pal_pkg::KIND_NONE:
            begin
                status_next = pal_pkg::ST_OK;
            end
            default:
            begin
                status_next = pal_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                op_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                op_valid_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                len_reg       <= len_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= pal_pkg::kind_t'(s_tdata[1:0]);
            pos_reg  <= s_tdata[7:2];
            val_reg  <= s_tdata[39:8];
        end
        if (exec_fire)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            found_reg   <= found_next;
            length_reg  <= len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, 6'(length_reg), 6'(found_reg), removed_reg, status_reg};

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_array_list_unit: random and directed
// insert, delete and search transactions against a shadow copy of the list.
// Depends on pal_pkg and the RTL of the unit; needs no other files.

module tb_top;

    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int END_SETTLE     = 8;

    typedef struct packed {
        logic [1:0]                status;
        logic [31:0]               removed;
        logic [pal_pkg::LEN_W-1:0] found;
        logic [pal_pkg::LEN_W-1:0] len;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [31:0]  shadow_store [pal_pkg::CAPACITY];
    int           shadow_len = 0;
    list_result_t pending_results [$];

    bit idle_en = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int ready_wait = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int kind_count [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};
    int peak_len = 0;

    list_result_t got_result;
    list_result_t want_result;

    positional_array_list_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic list_result_t apply_list_op(input logic [1:0] kind,
                                                   input logic [5:0] pos,
                                                   input logic [31:0] value);
        list_result_t res;
        int k;
        int p;
        res = '0;
        p = int'(pos);
        case (kind)
            pal_pkg::KIND_INSERT:
            begin
                if (p < 1 || p > shadow_len + 1)
                    res.status = pal_pkg::ST_BADPOS;
                else if (shadow_len >= pal_pkg::CAPACITY)
                    res.status = pal_pkg::ST_FULL;
                else
                begin
                    for (k = shadow_len; k >= p; k--)
                        shadow_store[k] = shadow_store[k - 1];
                    shadow_store[p - 1] = value;
                    shadow_len++;
                end
            end
            pal_pkg::KIND_DELETE:
            begin
                if (p < 1 || p > shadow_len)
                    res.status = pal_pkg::ST_BADPOS;
                else
                begin
                    res.removed = shadow_store[p - 1];
                    for (k = p; k < shadow_len; k++)
                        shadow_store[k - 1] = shadow_store[k];
                    shadow_len--;
                end
            end
            pal_pkg::KIND_SEARCH:
            begin
                res.status = pal_pkg::ST_NOTFOUND;
                for (k = 0; k < shadow_len; k++)
                begin
                    if (shadow_store[k] == value)
                    begin
                        res.found = pal_pkg::LEN_W'(k + 1);
                        res.status = pal_pkg::ST_OK;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.len = pal_pkg::LEN_W'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("ERROR at %0t: %s got 0x%08h expected 0x%08h", $realtime, field, got, want);
    endtask

    task automatic send_list_op(input logic [1:0] kind, input logic [5:0] pos,
                                input logic [31:0] value);
        list_result_t res;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {value, pos, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = apply_list_op(kind, pos, value);
        pending_results.push_back(res);
        kind_count[kind]++;
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($urandom_range(0, 6)) - 32'd3;
            3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [5:0] pick_position(input int upper);
        if (upper >= 1 && $urandom_range(0, 99) < 85)
            return 6'($urandom_range(1, upper));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic random_list_op(input int insert_pct);
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 3)
            send_list_op(pal_pkg::KIND_NONE, 6'($urandom_range(0, 63)), $urandom);
        else if (r < 3 + insert_pct)
            send_list_op(pal_pkg::KIND_INSERT, pick_position(shadow_len + 1), pick_value());
        else if ($urandom_range(0, 99) < 60)
            send_list_op(pal_pkg::KIND_DELETE, pick_position(shadow_len), $urandom);
        else
        begin
            if (shadow_len > 0 && $urandom_range(0, 99) < 70)
                v = shadow_store[$urandom_range(0, shadow_len - 1)];
            else
                v = pick_value();
            send_list_op(pal_pkg::KIND_SEARCH, 6'($urandom_range(0, 63)), v);
        end
    endtask

    task automatic test_directed_edges();
        send_list_op(pal_pkg::KIND_DELETE, 6'd1, 32'd0);
        send_list_op(pal_pkg::KIND_DELETE, 6'd0, 32'd0);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, 32'd0);
        send_list_op(pal_pkg::KIND_INSERT, 6'd0, 32'd5);
        send_list_op(pal_pkg::KIND_INSERT, 6'd2, 32'd5);
        send_list_op(pal_pkg::KIND_INSERT, 6'd1, 32'h8000_0000);
        send_list_op(pal_pkg::KIND_INSERT, 6'd2, 32'h7FFF_FFFF);
        send_list_op(pal_pkg::KIND_INSERT, 6'd1, 32'd0);
        send_list_op(pal_pkg::KIND_INSERT, 6'd2, 32'hFFFF_FFFF);
        send_list_op(pal_pkg::KIND_INSERT, 6'd63, 32'd9);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, 32'h7FFF_FFFF);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, 32'h8000_0000);
        send_list_op(pal_pkg::KIND_INSERT, 6'd5, 32'd0);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, 32'd0);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, 32'd12345);
        send_list_op(pal_pkg::KIND_NONE, 6'd63, 32'hFFFF_FFFF);
        send_list_op(pal_pkg::KIND_DELETE, 6'd6, 32'd0);
        send_list_op(pal_pkg::KIND_DELETE, 6'd63, 32'd0);
        send_list_op(pal_pkg::KIND_DELETE, 6'd5, 32'd0);
        send_list_op(pal_pkg::KIND_DELETE, 6'd1, 32'd0);
        send_list_op(pal_pkg::KIND_DELETE, 6'd2, 32'd0);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd63, 32'h7FFF_FFFF);
    endtask

    task automatic test_fill_and_overflow();
        while (shadow_len < pal_pkg::CAPACITY)
            send_list_op(pal_pkg::KIND_INSERT, 6'($urandom_range(1, shadow_len + 1)),
                         pick_value());
        send_list_op(pal_pkg::KIND_INSERT, 6'(pal_pkg::CAPACITY + 1), 32'd1);
        send_list_op(pal_pkg::KIND_INSERT, 6'd1, 32'd1);
        send_list_op(pal_pkg::KIND_INSERT, 6'(pal_pkg::CAPACITY + 2), 32'd1);
        send_list_op(pal_pkg::KIND_INSERT, 6'd0, 32'd1);
        send_list_op(pal_pkg::KIND_SEARCH, 6'd0, shadow_store[pal_pkg::CAPACITY - 1]);
        send_list_op(pal_pkg::KIND_DELETE, 6'(pal_pkg::CAPACITY + 1), 32'd0);
        while (shadow_len > 0)
            send_list_op(pal_pkg::KIND_DELETE, 6'($urandom_range(1, shadow_len)), 32'd0);
        wait_results_done();
    endtask

    task automatic test_random_phase(input int count, input int insert_pct);
        repeat (count)
            random_list_op(insert_pct);
    endtask

    task automatic test_output_stall();
        hold_req <= hold_req + 1;
        repeat (20)
            random_list_op(50);
        wait_results_done();
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            ready_wait <= LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (ready_wait > 0)
        begin
            ready_wait <= ready_wait - 1;
            m_tready <= 1'b0;
        end
        else if (rst_n && idle_en && $urandom_range(0, 4) == 0)
        begin
            ready_wait <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result.status = m_tdata[1:0];
            got_result.removed = m_tdata[33:2];
            got_result.found = m_tdata[39:34];
            got_result.len = m_tdata[45:40];
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            else
            begin
                want_result = pending_results.pop_front();
                status_seen[got_result.status]++;
                if (got_result.status != want_result.status)
                    report_mismatch("status", 32'(got_result.status),
                                    32'(want_result.status));
                if (got_result.removed != want_result.removed)
                    report_mismatch("removed_value", got_result.removed,
                                    want_result.removed);
                if (got_result.found != want_result.found)
                    report_mismatch("found_position", 32'(got_result.found),
                                    32'(want_result.found));
                if (got_result.len != want_result.len)
                    report_mismatch("length_after", 32'(got_result.len),
                                    32'(want_result.len));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL positional_array_list_unit");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_fill_and_overflow();
        test_random_phase(300, 70);
        test_random_phase(250, 25);
        test_output_stall();
        test_random_phase(250, 45);
        idle_en = 1'b0;
        test_random_phase(250, 45);
        wait_results_done();
        repeat (END_SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", 32'(pending_results.size()), 32'd0);
        $display("Ran %0d inserts, %0d deletes, %0d searches, %0d unused kinds; peak length %0d.",
                 kind_count[pal_pkg::KIND_INSERT], kind_count[pal_pkg::KIND_DELETE],
                 kind_count[pal_pkg::KIND_SEARCH], kind_count[pal_pkg::KIND_NONE], peak_len);
        $display("Statuses seen: ok %0d, bad position %0d, full %0d, not found %0d.",
                 status_seen[pal_pkg::ST_OK], status_seen[pal_pkg::ST_BADPOS],
                 status_seen[pal_pkg::ST_FULL], status_seen[pal_pkg::ST_NOTFOUND]);
        if (error_count == 0)
            $display("PASS positional_array_list_unit");
        else
            $display("FAIL positional_array_list_unit");
        $finish;
    end

endmodule
